FILE: src/lssd_pkg.sv
// ----------------------------------------------------------------------------
// lssd_pkg
// Types, register codes and constants shared by the swipe detector files.
// ----------------------------------------------------------------------------
package lssd_pkg;

    // Sample and index sizing
    localparam int SAMPLE_BITS = 12;
    localparam int MAX_VALUES  = 16;
    localparam int INDEX_BITS  = 4;
    localparam int COUNT_BITS  = 5;
    localparam int TIMER_BITS  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [SAMPLE_BITS-1:0]   t_sample;
    typedef logic [INDEX_BITS-1:0]    t_index;
    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [TIMER_BITS-1:0]    t_timer;
    typedef logic [1:0]               t_mode;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    // Configuration register indexes
    localparam t_cfg_idx CFG_DEBOUNCE  = 3'd0;
    localparam t_cfg_idx CFG_MIN_SWIPE = 3'd1;
    localparam t_cfg_idx CFG_MAX_SWIPE = 3'd2;
    localparam t_cfg_idx CFG_RECAL     = 3'd3;
    localparam t_cfg_idx CFG_MODE      = 3'd4;
    localparam t_cfg_idx CFG_VCOUNT    = 3'd5;

    // Backlight modes; the unused code behaves as automatic
    localparam t_mode MODE_OFF  = 2'd0;
    localparam t_mode MODE_ON   = 2'd1;
    localparam t_mode MODE_AUTO = 2'd2;

    // Register reset values
    localparam t_timer RST_DEBOUNCE  = 16'd50;
    localparam t_timer RST_MIN_SWIPE = 16'd150;
    localparam t_timer RST_MAX_SWIPE = 16'd2500;
    localparam t_timer RST_RECAL     = 16'd60000;
    localparam t_mode  RST_MODE      = MODE_AUTO;
    localparam t_count RST_VCOUNT    = 5'd4;

    localparam t_timer  TIMER_MAX   = 16'hFFFF;
    localparam t_sample DARK_OFFSET = 12'd100;
    localparam t_count  COUNT_MAX   = t_count'(MAX_VALUES);
    localparam t_count  COUNT_MIN   = 5'd1;

    typedef struct packed {
        t_timer debounce_ticks;
        t_timer min_swipe_ticks;
        t_timer max_swipe_ticks;
        t_timer recal_interval_ticks;
        t_mode  display_mode;
        t_count value_count;
    } t_cfg;

    typedef struct packed {
        t_sample light_sample;
    } t_in_item;

    typedef struct packed {
        logic    swipe_seen;
        t_index  selected_index;
        logic    backlight_on;
        logic    stable_dark;
        t_sample dark_threshold;
        logic    recalibrated;
    } t_out_item;

    // Threshold from one sample: max(0, min(floor(3v/4), v-100))
    function automatic t_sample calc_threshold(input t_sample v);
        logic [SAMPLE_BITS+1:0] triple;
        t_sample                three_q;
        t_sample                offset;
        triple  = {2'b00, v} + {1'b0, v, 1'b0};
        three_q = triple[SAMPLE_BITS+1:2];
        offset  = (v >= DARK_OFFSET) ? (v - DARK_OFFSET) : '0;
        return (three_q < offset) ? three_q : offset;
    endfunction

endpackage

FILE: src/lssd_chan_if.sv
// ----------------------------------------------------------------------------
// lssd_chan_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface lssd_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/lssd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lssd_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module lssd_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  lssd_pkg::t_cfg_idx i_cfg_idx,
    input  lssd_pkg::t_cfg_data i_cfg_wdata,
    output lssd_pkg::t_cfg     o_cfg
);

    lssd_pkg::t_cfg r_cfg;

    // Write the addressed register; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks       <= lssd_pkg::RST_DEBOUNCE;
            r_cfg.min_swipe_ticks      <= lssd_pkg::RST_MIN_SWIPE;
            r_cfg.max_swipe_ticks      <= lssd_pkg::RST_MAX_SWIPE;
            r_cfg.recal_interval_ticks <= lssd_pkg::RST_RECAL;
            r_cfg.display_mode         <= lssd_pkg::RST_MODE;
            r_cfg.value_count          <= lssd_pkg::RST_VCOUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lssd_pkg::CFG_DEBOUNCE:  r_cfg.debounce_ticks       <= i_cfg_wdata;
                lssd_pkg::CFG_MIN_SWIPE: r_cfg.min_swipe_ticks      <= i_cfg_wdata;
                lssd_pkg::CFG_MAX_SWIPE: r_cfg.max_swipe_ticks      <= i_cfg_wdata;
                lssd_pkg::CFG_RECAL:     r_cfg.recal_interval_ticks <= i_cfg_wdata;
                lssd_pkg::CFG_MODE:      r_cfg.display_mode         <= i_cfg_wdata[1:0];
                lssd_pkg::CFG_VCOUNT:    r_cfg.value_count <= i_cfg_wdata[lssd_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/lssd_core.sv
// ----------------------------------------------------------------------------
// lssd_core
// Detector state, per-tick update logic and the result register.
// ----------------------------------------------------------------------------
module lssd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lssd_pkg::t_cfg      i_cfg,
    input  logic                i_item_valid,
    input  lssd_pkg::t_sample   i_sample,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lssd_pkg::t_out_item o_out_item
);

    // Detector state
    lssd_pkg::t_sample r_thresh;
    logic              r_calibrated;
    logic              r_last_dark;
    lssd_pkg::t_timer  r_debounce_cnt;
    logic              r_stable_dark;
    lssd_pkg::t_timer  r_dark_cnt;
    lssd_pkg::t_timer  r_recal_cnt;
    logic              r_auto_bl;
    lssd_pkg::t_index  r_index;

    lssd_pkg::t_sample n_thresh;
    logic              n_calibrated;
    lssd_pkg::t_timer  n_debounce_cnt;
    logic              n_stable_dark;
    lssd_pkg::t_timer  n_dark_cnt;
    lssd_pkg::t_timer  n_recal_cnt;
    logic              n_auto_bl;
    lssd_pkg::t_index  n_index;

    // Result register
    logic                r_out_valid;
    lssd_pkg::t_out_item r_out_item;
    lssd_pkg::t_out_item n_out_item;

    lssd_pkg::t_sample cal_thresh;
    lssd_pkg::t_count  eff_count;
    lssd_pkg::t_count  idx_inc;
    logic              dark;
    logic              stable;
    logic              swipe;
    logic              recal;
    logic              bl_now;
    logic              is_auto;

    // Take an item when the result register is free or being emptied
    assign o_take = i_item_valid && (!r_out_valid || i_out_ready);

    assign cal_thresh = lssd_pkg::calc_threshold(i_sample);
    assign is_auto    = (i_cfg.display_mode != lssd_pkg::MODE_OFF) &&
                        (i_cfg.display_mode != lssd_pkg::MODE_ON);

    // Clamp the value count to 1..MAX_VALUES
    always_comb begin
        priority if (i_cfg.value_count < lssd_pkg::COUNT_MIN) begin
            eff_count = lssd_pkg::COUNT_MIN;
        end else if (i_cfg.value_count > lssd_pkg::COUNT_MAX) begin
            eff_count = lssd_pkg::COUNT_MAX;
        end else begin
            eff_count = i_cfg.value_count;
        end
    end

    assign idx_inc = {1'b0, r_index} + lssd_pkg::t_count'(1);

    // Backlight drive before this tick's update
    always_comb begin
        unique case (i_cfg.display_mode)
            lssd_pkg::MODE_OFF: bl_now = 1'b0;
            lssd_pkg::MODE_ON:  bl_now = 1'b1;
            default:            bl_now = r_auto_bl;
        endcase
    end

    // One tick: advance timers, calibrate, classify, debounce, evaluate
    always_comb begin
        n_thresh      = r_thresh;
        n_calibrated  = r_calibrated;
        n_stable_dark = r_stable_dark;
        n_auto_bl     = r_auto_bl;
        n_index       = r_index;
        swipe         = 1'b0;
        recal         = 1'b0;

        n_debounce_cnt = (r_debounce_cnt == lssd_pkg::TIMER_MAX) ? r_debounce_cnt
                       : r_debounce_cnt + lssd_pkg::t_timer'(1);
        n_dark_cnt     = (r_dark_cnt == lssd_pkg::TIMER_MAX) ? r_dark_cnt
                       : r_dark_cnt + lssd_pkg::t_timer'(1);
        n_recal_cnt    = (r_recal_cnt == lssd_pkg::TIMER_MAX) ? r_recal_cnt
                       : r_recal_cnt + lssd_pkg::t_timer'(1);

        // First sample or interval expired: recalibrate
        if (!r_calibrated || n_recal_cnt > i_cfg.recal_interval_ticks) begin
            n_thresh     = cal_thresh;
            n_calibrated = 1'b1;
            n_recal_cnt  = '0;
            recal        = 1'b1;
        end

        dark = i_sample <= n_thresh;
        if (dark != r_last_dark) begin
            n_debounce_cnt = '0;
        end
        stable = n_debounce_cnt > i_cfg.debounce_ticks;

        if (stable) begin
            if (dark && !r_stable_dark) begin
                // Dark period starts
                n_stable_dark = 1'b1;
                n_dark_cnt    = '0;
            end else if (dark) begin
                // Long darkness: room lights changed
                if (n_dark_cnt > i_cfg.max_swipe_ticks && bl_now) begin
                    n_thresh     = cal_thresh;
                    n_calibrated = 1'b1;
                    n_recal_cnt  = '0;
                    recal        = 1'b1;
                    if (is_auto) begin
                        n_auto_bl = 1'b0;
                    end
                end
            end else if (r_stable_dark) begin
                // Light ends a dark period
                n_stable_dark = 1'b0;
                if (n_dark_cnt >= i_cfg.min_swipe_ticks &&
                    n_dark_cnt <= i_cfg.max_swipe_ticks) begin
                    n_index = (idx_inc >= eff_count) ? '0
                            : idx_inc[lssd_pkg::INDEX_BITS-1:0];
                    swipe   = 1'b1;
                end else if (n_dark_cnt > i_cfg.max_swipe_ticks) begin
                    n_thresh     = cal_thresh;
                    n_calibrated = 1'b1;
                    n_recal_cnt  = '0;
                    recal        = 1'b1;
                    if (is_auto) begin
                        n_auto_bl = 1'b1;
                    end
                end
            end
        end

        n_out_item.swipe_seen     = swipe;
        n_out_item.selected_index = n_index;
        unique case (i_cfg.display_mode)
            lssd_pkg::MODE_OFF: n_out_item.backlight_on = 1'b0;
            lssd_pkg::MODE_ON:  n_out_item.backlight_on = 1'b1;
            default:            n_out_item.backlight_on = n_auto_bl;
        endcase
        n_out_item.stable_dark    = n_stable_dark;
        n_out_item.dark_threshold = n_thresh;
        n_out_item.recalibrated   = recal;
    end

    // Commit state on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh       <= '0;
            r_calibrated   <= 1'b0;
            r_last_dark    <= 1'b0;
            r_debounce_cnt <= '0;
            r_stable_dark  <= 1'b0;
            r_dark_cnt     <= '0;
            r_recal_cnt    <= '0;
            r_auto_bl      <= 1'b1;
            r_index        <= '0;
        end else if (o_take) begin
            r_thresh       <= n_thresh;
            r_calibrated   <= n_calibrated;
            r_last_dark    <= dark;
            r_debounce_cnt <= n_debounce_cnt;
            r_stable_dark  <= n_stable_dark;
            r_dark_cnt     <= n_dark_cnt;
            r_recal_cnt    <= n_recal_cnt;
            r_auto_bl      <= n_auto_bl;
            r_index        <= n_index;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: src/light_sensor_swipe_detector_top.sv
// ----------------------------------------------------------------------------
// light_sensor_swipe_detector_top
// Light-sensor swipe detector: threshold tracking, debounce, swipe counting
// and backlight control, one result item per sample item.
// ----------------------------------------------------------------------------
// Each light sample item yields exactly one result item. The block takes one
// item per clock cycle when the output side keeps up; an accepted sample is
// held in the input register, its result in the result register. If the
// output stalls, one more sample is held in the input register before
// i_in.ready drops. Configuration is written through i_cfg_we/i_cfg_idx/
// i_cfg_wdata and must only change while no item is in flight; indexes 6
// and 7 are ignored.
module light_sensor_swipe_detector_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  lssd_pkg::t_cfg_idx  i_cfg_idx,
    input  lssd_pkg::t_cfg_data i_cfg_wdata,
    lssd_chan_if.sink           i_in,
    lssd_chan_if.source         o_out
);

    lssd_pkg::t_cfg      cfg;
    logic                take;
    logic                out_valid;
    lssd_pkg::t_out_item out_item;

    // Input register
    logic              r_s1_valid;
    lssd_pkg::t_sample r_s1_sample;

    lssd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Accept when the input register is empty or drains this cycle
    assign i_in.ready = !r_s1_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_sample <= i_in.payload.light_sample;
        end
    end

    lssd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (r_s1_valid),
        .i_sample     (r_s1_sample),
        .o_take       (take),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out.ready),
        .o_out_item   (out_item)
    );

    assign o_out.valid   = out_valid;
    assign o_out.payload = out_item;

endmodule
